// ===== rtl/core/ufb_pkg.sv =====
`default_nettype none
package ufb_pkg;

	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'h1021;
	localparam logic [15:0] CrcTop  = 16'h8000;

	localparam logic [7:0] SofFirstRst  = 8'hAA;
	localparam logic [7:0] SofSecondRst = 8'h55;

	localparam int QueueDepth = 4;

	typedef enum logic {
		CFG_SOF_FIRST  = 1'b0,
		CFG_SOF_SECOND = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		KIND_HEADER  = 1'b0,
		KIND_PAYLOAD = 1'b1
	} kind_t;

	// One classified item on its way to the serializer. For a header, lead is the
	// message id; for a payload item it is the data byte.
	typedef struct packed {
		logic        is_hdr;
		logic [7:0]  lead;
		logic [15:0] len;
		logic        crc_end;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CrcTop) != 16'h0000) begin
				c = (c << 1) ^ CrcPoly;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ufb_in_if.sv =====
`default_nettype none
interface ufb_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  msg_id;
	logic [15:0] payload_length;
	logic [7:0]  data_byte;

	modport source (output valid, kind, msg_id, payload_length, data_byte, input ready);
	modport sink (input valid, kind, msg_id, payload_length, data_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ufb_out_if.sv =====
`default_nettype none
interface ufb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_end;

	modport source (output valid, out_byte, run_last, frame_end, input ready);
	modport sink (input valid, out_byte, run_last, frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ufb_front.sv =====
`default_nettype none
module ufb_front
	import ufb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	ufb_in_if.sink         items,
	input  wire q_status_t q_stat,
	output logic           push,
	output cmd_t           push_cmd
);

	logic        in_frame_q;
	logic [15:0] bytes_left_q;
	logic        accept;
	logic        last_byte;

	assign items.ready = !q_stat.full;
	assign accept      = items.valid && items.ready;
	assign last_byte   = (bytes_left_q == 16'd1);

	always_comb begin
		push_cmd = '0;
		push     = 1'b0;
		if (kind_t'(items.kind) == KIND_HEADER) begin
			push_cmd.is_hdr  = 1'b1;
			push_cmd.lead    = items.msg_id;
			push_cmd.len     = items.payload_length;
			push_cmd.crc_end = (items.payload_length == 16'd0);
			push             = accept;
		end else begin
			push_cmd.is_hdr  = 1'b0;
			push_cmd.lead    = items.data_byte;
			push_cmd.crc_end = last_byte;
			// Payload that arrives outside a frame is dropped here.
			push             = accept && in_frame_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			bytes_left_q <= '0;
		end else if (accept) begin
			if (kind_t'(items.kind) == KIND_HEADER) begin
				in_frame_q   <= (items.payload_length != 16'd0);
				bytes_left_q <= items.payload_length;
			end else if (in_frame_q) begin
				bytes_left_q <= bytes_left_q - 16'd1;
				if (last_byte) begin
					in_frame_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ufb_queue.sv =====
`default_nettype none
module ufb_queue
	import ufb_pkg::*;
#(
	parameter int DEPTH = QueueDepth
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire cmd_t  push_cmd,
	input  wire logic  pop,
	output cmd_t       head,
	output q_status_t  q_stat
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	cmd_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign q_stat.full  = (count_q == FullCnt);
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ufb_back.sv =====
`default_nettype none
module ufb_back
	import ufb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] sof_first,
	input  wire logic [7:0] sof_second,
	input  wire cmd_t       head,
	input  wire q_status_t  q_stat,
	output logic            pop,
	ufb_out_if.source       frames
);

	// STEP_LEAD is the first byte of any command: sof_first for a header,
	// the data byte for a payload item.
	typedef enum logic [2:0] {
		STEP_LEAD = 3'd0,
		STEP_SOF2 = 3'd1,
		STEP_ID   = 3'd2,
		STEP_LH   = 3'd3,
		STEP_LL   = 3'd4,
		STEP_CRCH = 3'd5,
		STEP_CRCL = 3'd6
	} step_t;

	step_t       step_q;
	step_t       step_nx;
	logic [15:0] crc_q;
	logic [15:0] crc_nx;
	logic        valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        end_q;
	logic [7:0]  byte_nx;
	logic        done;
	logic        fend;
	logic        advance;

	assign advance = !q_stat.empty && (!valid_q || frames.ready);
	assign pop     = advance && done;

	always_comb begin
		step_nx = STEP_LEAD;
		crc_nx  = crc_q;
		byte_nx = head.lead;
		done    = 1'b0;
		fend    = 1'b0;
		case (step_q)
			STEP_LEAD: begin
				if (head.is_hdr) begin
					byte_nx = sof_first;
					step_nx = STEP_SOF2;
				end else begin
					byte_nx = head.lead;
					crc_nx  = crc_feed(crc_q, head.lead);
					done    = !head.crc_end;
					step_nx = head.crc_end ? STEP_CRCH : STEP_LEAD;
				end
			end
			STEP_SOF2: begin
				byte_nx = sof_second;
				step_nx = STEP_ID;
			end
			STEP_ID: begin
				byte_nx = head.lead;
				crc_nx  = crc_feed(CrcInit, head.lead);
				step_nx = STEP_LH;
			end
			STEP_LH: begin
				byte_nx = head.len[15:8];
				crc_nx  = crc_feed(crc_q, head.len[15:8]);
				step_nx = STEP_LL;
			end
			STEP_LL: begin
				byte_nx = head.len[7:0];
				crc_nx  = crc_feed(crc_q, head.len[7:0]);
				done    = !head.crc_end;
				step_nx = head.crc_end ? STEP_CRCH : STEP_LEAD;
			end
			STEP_CRCH: begin
				byte_nx = crc_q[15:8];
				step_nx = STEP_CRCL;
			end
			STEP_CRCL: begin
				byte_nx = crc_q[7:0];
				crc_nx  = CrcInit;
				done    = 1'b1;
				fend    = 1'b1;
				step_nx = STEP_LEAD;
			end
			default: begin
				step_nx = STEP_LEAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_LEAD;
			crc_q   <= CrcInit;
			valid_q <= 1'b0;
			byte_q  <= '0;
			last_q  <= 1'b0;
			end_q   <= 1'b0;
		end else begin
			if (advance) begin
				step_q  <= step_nx;
				crc_q   <= crc_nx;
				valid_q <= 1'b1;
				byte_q  <= byte_nx;
				last_q  <= done;
				end_q   <= fend;
			end else if (frames.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign frames.valid     = valid_q;
	assign frames.out_byte  = byte_q;
	assign frames.run_last  = last_q;
	assign frames.frame_end = end_q;

endmodule
`default_nettype wire

// ===== rtl/core/uart_frame_builder_crc16.sv =====
// Packet framer with a CRC16-CCITT trailer (poly 0x1021, init 0xFFFF, MSB first).
// Channel items takes header items (kind 0: msg_id, payload_length) and payload
// items (kind 1: data_byte). Channel frames delivers the framed byte stream, one
// byte per transaction, with run_last on the final byte caused by an item and
// frame_end on the CRC low byte that closes a frame.
// A header produces sof_first, sof_second, id, length high, length low, and the
// two CRC bytes at once if the length is zero. A payload byte produces itself,
// followed by the CRC bytes when it is the last one of its frame. Payload outside
// a frame is dropped; a new header abandons an open frame without a CRC.
// An accepted item enters a small command queue, and its first byte is then
// loaded into the output register. The serializer emits one byte per cycle
// while frames is ready, so payload items sustain one per cycle; a header
// occupies five bytes, or seven with a zero length; a frame's last byte adds two.
// Reset clears the queue and the output register, sets the CRC to 0xFFFF and the
// start-of-frame registers to 0xAA and 0x55. When frames is stalled the output
// byte holds, the queue fills, and items.ready drops only once the queue is full.
// Configuration writes (cfg_wen, cfg_idx, cfg_data) take effect on the next edge.
`default_nettype none
module uart_frame_builder_crc16
	import ufb_pkg::*;
#(
	parameter int QUEUE_DEPTH = QueueDepth
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	ufb_in_if.sink          items,
	ufb_out_if.source       frames,
	input  wire logic       cfg_wen,
	input  wire logic       cfg_idx,
	input  wire logic [7:0] cfg_data
);

	logic [7:0] sof_first_q;
	logic [7:0] sof_second_q;
	logic       push;
	cmd_t       push_cmd;
	logic       pop;
	cmd_t       head;
	q_status_t  q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof_first_q  <= SofFirstRst;
			sof_second_q <= SofSecondRst;
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_SOF_FIRST:  sof_first_q  <= cfg_data;
				CFG_SOF_SECOND: sof_second_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ufb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	ufb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	ufb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.sof_first  (sof_first_q),
		.sof_second (sof_second_q),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.frames     (frames)
	);

endmodule
`default_nettype wire

// ===== rtl/core/ufb_checker.sv =====
`default_nettype none
module ufb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       frames_valid,
	input wire logic       frames_ready,
	input wire logic [7:0] frames_byte,
	input wire logic       frames_last,
	input wire logic       frames_end
);

	// A stalled output byte must not change or disappear.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frames_valid && !frames_ready |=> frames_valid && $stable(frames_byte)
			&& $stable(frames_last) && $stable(frames_end))
		else $error("stalled output byte changed");

	// The CRC low byte is always the last byte of the item that caused it.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		frames_valid && frames_end |-> frames_last)
		else $error("frame_end without run_last");

	// A frame end follows the CRC high byte, so two ends never come back to back.
	a_end_gap: assert property (@(posedge clk) disable iff (!arst_n)
		frames_valid && frames_ready && frames_end |=> !(frames_valid && frames_end))
		else $error("two frame ends in consecutive bytes");

	// Reset empties the output register by the next edge.
	a_reset: assert property (@(posedge clk) !arst_n |=> !frames_valid)
		else $error("output valid during reset");

endmodule

bind uart_frame_builder_crc16 ufb_checker u_ufb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.frames_valid (frames.valid),
	.frames_ready (frames.ready),
	.frames_byte  (frames.out_byte),
	.frames_last  (frames.run_last),
	.frames_end   (frames.frame_end)
);
`default_nettype wire
